// File: hw/rtl/mvd_pkg.sv
// Shared types and constants for the MAVLink stream deframer.
package mvd_pkg;

  localparam logic [7:0] START_V1        = 8'hFE;
  localparam logic [7:0] START_V2        = 8'hFD;
  localparam logic [7:0] SIGNED_MASK     = 8'h01;
  localparam logic [7:0] CHECKSUM_BYTES  = 8'd2;
  localparam logic [7:0] SIGNATURE_BYTES = 8'd13;

  // Header byte positions after the start byte.
  localparam logic [3:0] HDR_LEN      = 4'd0;
  localparam logic [3:0] HDR_INCOMPAT = 4'd1;
  localparam logic [3:0] V1_SYS       = 4'd2;
  localparam logic [3:0] V1_COMP      = 4'd3;
  localparam logic [3:0] V1_MSG       = 4'd4;
  localparam logic [3:0] V2_SYS       = 4'd4;
  localparam logic [3:0] V2_COMP      = 4'd5;
  localparam logic [3:0] V2_MSG0      = 4'd6;
  localparam logic [3:0] V2_MSG1      = 4'd7;
  localparam logic [3:0] V2_MSG2      = 4'd8;

  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  typedef struct packed {
    logic        last;
    logic        signed_frame;
    logic        version_two;
    logic [7:0]  component_id;
    logic [7:0]  system_id;
    logic [23:0] message_id;
    logic [7:0]  payload_length;
    logic [7:0]  byte_index;
    logic [7:0]  data_byte;
  } result_t;

endpackage

// File: hw/rtl/mvd_parser.sv
// Frame state machine: header capture, payload tagging and trailer skip.
module mvd_parser
  import mvd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic        frame_version, frame_version_next;
  logic [7:0]  length_held, length_held_next;
  logic        signed_held, signed_held_next;
  logic [7:0]  system_held, system_held_next;
  logic [7:0]  component_held, component_held_next;
  logic [23:0] message_held, message_held_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  trailer_len;
  logic        hdr_done;

  assign trailer_len = signed_held ? (CHECKSUM_BYTES + SIGNATURE_BYTES) : CHECKSUM_BYTES;
  assign hdr_done    = frame_version ? (header_count == V2_MSG2) : (header_count == V1_MSG);

  // next state
  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    frame_version_next  = frame_version;
    length_held_next    = length_held;
    signed_held_next    = signed_held;
    system_held_next    = system_held;
    component_held_next = component_held;
    message_held_next   = message_held;
    bytes_left_next     = bytes_left;
    case (phase)
      PH_HEADER: begin
        header_count_next = header_count + 4'd1;
        if (header_count == HDR_LEN) begin
          length_held_next = rx_byte;
        end
        if (!frame_version) begin
          case (header_count)
            V1_SYS:  system_held_next = rx_byte;
            V1_COMP: component_held_next = rx_byte;
            V1_MSG:  message_held_next = {16'd0, rx_byte};
            default: ;
          endcase
        end else begin
          case (header_count)
            HDR_INCOMPAT: signed_held_next = |(rx_byte & SIGNED_MASK);
            V2_SYS:       system_held_next = rx_byte;
            V2_COMP:      component_held_next = rx_byte;
            V2_MSG0:      message_held_next = {16'd0, rx_byte};
            V2_MSG1:      message_held_next = {8'd0, rx_byte, message_held[7:0]};
            V2_MSG2:      message_held_next = {rx_byte, message_held[15:0]};
            default: ;
          endcase
        end
        if (hdr_done) begin
          if (length_held != 8'd0) begin
            phase_next      = PH_PAYLOAD;
            bytes_left_next = length_held;
          end else begin
            phase_next      = PH_TRAILER;
            bytes_left_next = trailer_len;
          end
        end
      end
      PH_PAYLOAD: begin
        bytes_left_next = bytes_left - 8'd1;
        if (bytes_left == 8'd1) begin
          phase_next      = PH_TRAILER;
          bytes_left_next = trailer_len;
        end
      end
      PH_TRAILER: begin
        if (bytes_left <= 8'd1) begin
          phase_next        = PH_HUNT;
          bytes_left_next   = 8'd0;
          header_count_next = 4'd0;
        end else begin
          bytes_left_next = bytes_left - 8'd1;
        end
      end
      default: begin
        if (rx_byte == START_V1 || rx_byte == START_V2) begin
          phase_next          = PH_HEADER;
          header_count_next   = 4'd0;
          frame_version_next  = (rx_byte == START_V2);
          length_held_next    = 8'd0;
          signed_held_next    = 1'b0;
          system_held_next    = 8'd0;
          component_held_next = 8'd0;
          message_held_next   = 24'd0;
          bytes_left_next     = 8'd0;
        end
      end
    endcase
  end

  // result
  always_comb begin
    res.data_byte      = 8'd0;
    res.byte_index     = 8'd0;
    res.payload_length = length_held;
    res.message_id     = message_held;
    res.system_id      = system_held;
    res.component_id   = component_held;
    res.version_two    = frame_version;
    res.signed_frame   = signed_held;
    res.last           = 1'b0;
    res_valid          = 1'b0;
    case (phase)
      PH_PAYLOAD: begin
        res_valid      = fire;
        res.data_byte  = rx_byte;
        res.byte_index = length_held - bytes_left;
      end
      PH_TRAILER: begin
        res_valid = fire && (bytes_left <= 8'd1);
        res.last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      header_count   <= 4'd0;
      frame_version  <= 1'b0;
      length_held    <= 8'd0;
      signed_held    <= 1'b0;
      system_held    <= 8'd0;
      component_held <= 8'd0;
      message_held   <= 24'd0;
      bytes_left     <= 8'd0;
    end else if (fire) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      frame_version  <= frame_version_next;
      length_held    <= length_held_next;
      signed_held    <= signed_held_next;
      system_held    <= system_held_next;
      component_held <= component_held_next;
      message_held   <= message_held_next;
      bytes_left     <= bytes_left_next;
    end
  end

endmodule

// File: hw/rtl/mvd_out_buf.sv
// Output register with a skid stage; ready toward the parser is registered.
module mvd_out_buf
  import mvd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_data,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    out_free;

  assign in_ready = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_valid) begin
        out_data <= in_data;
      end
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

// File: hw/rtl/mavlink_stream_deframer_top.sv
// MAVLink v1/v2 stream deframer, top level.
//
// Slave channel: one received serial byte per request on s_tdata.
// Master channel: one result per payload byte, tagged with the frame header
// (length, message id, system/component id, version, signed flag), plus an
// end-of-frame result with m_tlast high on the frame's final trailer byte.
// Hunting bytes, header bytes and other trailer bytes give no result.
// The checksum is not verified; start bytes inside a frame are frame data.
// Throughput: one byte per cycle while s_tready is high. A result reaches the
// master side through the output register, where it is held.
// When the receiver stalls, one more result is caught in the skid stage and
// s_tready drops until the output register drains; no result is lost.
// Reset (rst, synchronous) returns the parser to hunting for a start byte
// and empties the output and skid registers.
module mavlink_stream_deframer_top
  import mvd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,  // rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // data_byte, byte_index, payload_length, message_id[23:0], system_id,
  // component_id, version_two, signed_frame, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  logic    fire;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign fire = s_tvalid && s_tready;

  mvd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  mvd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {6'd0, out_res.signed_frame, out_res.version_two, out_res.component_id,
                    out_res.system_id, out_res.message_id, out_res.payload_length,
                    out_res.byte_index, out_res.data_byte};
  assign m_tlast = out_res.last;

  a_result_needs_request: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> fire)
    else $error("result produced without an accepted byte");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !$past(m_tready))
    else $error("input stalled while output could drain");

  a_eof_zero_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last |-> res.data_byte == 8'd0 && res.byte_index == 8'd0)
    else $error("end-of-frame result carries payload fields");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && s_tready)
    else $error("output not empty after reset");

endmodule
